// ===== rtl/assert_macros.svh =====
// Assertion macros for the checker module of the downscaler.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A concurrent assertion that is switched off while reset is high.
`define RBHD_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// A concurrent assertion that is checked at every edge, reset included.
`define RBHD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/rbhd_pkg.sv =====
// Package of types, constants and register indexes for the RGBA halving downscaler.
`timescale 1ns / 1ps
package rbhd_pkg;

   localparam int CHAN_W             = 8;
   localparam int CHANNELS           = 4;
   localparam int CFG_W              = 14;
   localparam int CSR_INDEX_W        = 2;
   localparam int PASS_W             = 3;
   localparam int SUM_W              = CHAN_W + 1;
   localparam int DEFAULT_MAX_WIDTH  = 8192;
   localparam int DEFAULT_MAX_PASSES = 3;

   localparam logic [CFG_W-1:0] RESET_IMAGE_WIDTH  = CFG_W'(1);
   localparam logic [CFG_W-1:0] RESET_IMAGE_HEIGHT = CFG_W'(1);
   localparam logic [CFG_W-1:0] RESET_SIDE_LIMIT   = CFG_W'(1024);

   localparam logic [CSR_INDEX_W-1:0] REG_IMAGE_WIDTH  = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] REG_IMAGE_HEIGHT = CSR_INDEX_W'(1);
   localparam logic [CSR_INDEX_W-1:0] REG_SIDE_LIMIT   = CSR_INDEX_W'(2);

   typedef struct packed {
      logic [CHAN_W-1:0] in_red;
      logic [CHAN_W-1:0] in_green;
      logic [CHAN_W-1:0] in_blue;
      logic [CHAN_W-1:0] in_alpha;
   } req_data_type;

   typedef struct packed {
      logic [CHAN_W-1:0] out_red;
      logic [CHAN_W-1:0] out_green;
      logic [CHAN_W-1:0] out_blue;
      logic [CHAN_W-1:0] out_alpha;
      logic              frame_end;
   } rsp_data_type;

   // Channel 0 is red, then green, blue and alpha.
   typedef logic [CHANNELS-1:0][CHAN_W-1:0] pixel_type;
   typedef logic [CHANNELS-1:0][SUM_W-1:0]  pair_sum_type;

   typedef struct packed {
      logic              valid;
      logic              last;
      logic [PASS_W-1:0] passes;
      pixel_type         pix;
   } token_type;

endpackage

// ===== rtl/rbhd_ram.sv =====
// Generic simple dual-port RAM with a registered read port.
`timescale 1ns / 1ps
module rbhd_ram #(
   parameter int WIDTH = 36,
   parameter int DEPTH = 4096,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/rbhd_stage.sv =====
// One 2x2 box-averaging stage with its row-sum memory and position counters.
`timescale 1ns / 1ps
module rbhd_stage #(
   parameter int STAGE     = 0,
   parameter int MAX_WIDTH = rbhd_pkg::DEFAULT_MAX_WIDTH,
   localparam int DIM_W    = $clog2(MAX_WIDTH + 1)
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                clear,
   input  logic [DIM_W-1:0]    image_width,
   input  logic [DIM_W-1:0]    image_height,
   input  rbhd_pkg::token_type in_tok,
   output logic                in_ready,
   output rbhd_pkg::token_type out_tok,
   input  logic                out_ready,
   output logic                at_origin
);

   localparam int POS_W     = $clog2(MAX_WIDTH);
   localparam int DEPTH_RAW = (MAX_WIDTH / 2) >> STAGE;
   localparam int DEPTH     = (DEPTH_RAW > 0) ? DEPTH_RAW : 1;
   localparam int ADDR_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int ROW_W     = rbhd_pkg::CHANNELS * rbhd_pkg::SUM_W;

   logic [POS_W-1:0]       col_ff, col_in, row_ff, row_in;
   rbhd_pkg::pixel_type    held_ff, held_in;
   rbhd_pkg::token_type    out_ff, out_in;
   logic [DIM_W-1:0]       ws, hs, ws_even, hs_even, col_ext, row_ext;
   logic                   active, counting, take, in_region, col_wrap, row_wrap;
   logic                   last_active, last_plain, emit;
   logic                   wr_en, rd_en;
   logic [ADDR_W-1:0]      addr;
   logic [ROW_W-1:0]       rd_data;
   rbhd_pkg::pair_sum_type pair, above;
   rbhd_pkg::pixel_type    avg;

   assign ws      = image_width >> STAGE;
   assign hs      = image_height >> STAGE;
   assign ws_even = {ws[DIM_W-1:1], 1'b0};
   assign hs_even = {hs[DIM_W-1:1], 1'b0};
   assign col_ext = DIM_W'(col_ff);
   assign row_ext = DIM_W'(row_ff);

   assign active    = in_tok.passes > rbhd_pkg::PASS_W'(STAGE);
   assign counting  = active || (STAGE == 0);
   assign in_ready  = !out_ff.valid || out_ready;
   assign take      = in_tok.valid && in_ready;
   assign in_region = (col_ext < ws_even) && (row_ext < hs_even);
   assign col_wrap  = DIM_W'(col_ext + DIM_W'(1)) >= ws;
   assign row_wrap  = DIM_W'(row_ext + DIM_W'(1)) >= hs;
   assign at_origin = (col_ff == '0) && (row_ff == '0);

   assign last_active = (col_ext == DIM_W'(ws_even - DIM_W'(1)))
                     && (row_ext == DIM_W'(hs_even - DIM_W'(1)));
   assign last_plain  = (col_ext == DIM_W'(ws - DIM_W'(1)))
                     && (row_ext == DIM_W'(hs - DIM_W'(1)));
   assign emit        = in_region && col_ff[0] && row_ff[0];

   assign addr  = ADDR_W'(col_ff >> 1);
   assign wr_en = take && active && in_region && col_ff[0] && !row_ff[0];
   assign rd_en = take && active && in_region && !col_ff[0] && row_ff[0];
   assign above = rbhd_pkg::pair_sum_type'(rd_data);

   always_comb begin
      for (int c = 0; c < rbhd_pkg::CHANNELS; c++) begin
         pair[c] = rbhd_pkg::SUM_W'(held_ff[c]) + rbhd_pkg::SUM_W'(in_tok.pix[c]);
         avg[c]  = rbhd_pkg::CHAN_W'((10'(above[c]) + 10'(pair[c]) + 10'd2) >> 2);
      end
   end

   rbhd_ram #(
      .WIDTH (ROW_W),
      .DEPTH (DEPTH)
   ) u_row_sums (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (addr),
      .wr_data (pair),
      .rd_en   (rd_en),
      .rd_addr (addr),
      .rd_data (rd_data)
   );

   always_comb begin
      col_in  = col_ff;
      row_in  = row_ff;
      held_in = held_ff;
      out_in  = out_ff;
      if (take && counting) begin
         col_in = col_wrap ? '0 : POS_W'(col_ff + POS_W'(1));
         if (col_wrap) begin
            row_in = row_wrap ? '0 : POS_W'(row_ff + POS_W'(1));
         end
      end
      if (take && active && in_region && !col_ff[0]) begin
         held_in = in_tok.pix;
      end
      if (in_ready) begin
         out_in.valid = 1'b0;
         if (in_tok.valid) begin
            if (active) begin
               out_in.valid  = emit;
               out_in.pix    = avg;
               out_in.passes = in_tok.passes;
               out_in.last   = (in_tok.passes == rbhd_pkg::PASS_W'(STAGE + 1)) && last_active;
            end else begin
               out_in      = in_tok;
               out_in.last = (STAGE == 0) ? last_plain : in_tok.last;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
      if (reset) begin
         out_ff.valid <= 1'b0;
      end else begin
         out_ff <= out_in;
      end
      held_ff <= held_in;
   end

   assign out_tok = out_ff;

endmodule

// ===== rtl/rgba_box_halving_downscaler_unit.sv =====
// Top level of the RGBA 2x2 box-filter halving downscaler.
//
//   Port group   Direction   Handshake          Carries
//   req_         in          valid / stall      one RGBA pixel per transaction
//   rsp_         out         valid / stall      one reduced pixel and frame_end
//   csr_         in          write enable       image_width, image_height, side_limit
//
// One pixel is taken every cycle while req_stall is low; each halving stage is one register
// stage, so a result is registered once in each of the MAX_PASSES stages on its way out.
// Each stage reads its row-sum memory on the left pixel of an odd row and uses
// the registered data on the right pixel, so a stage never stalls on its memory.
// Reset clears the counters and valid bits at once; the row-sum memories are not cleared.
// A result stall reaches req_stall combinationally only while every stage holds a token.
`timescale 1ns / 1ps
module rgba_box_halving_downscaler_unit #(
   parameter int MAX_WIDTH  = rbhd_pkg::DEFAULT_MAX_WIDTH,
   parameter int MAX_PASSES = rbhd_pkg::DEFAULT_MAX_PASSES
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  rbhd_pkg::req_data_type             req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output rbhd_pkg::rsp_data_type             rsp_data,
   input  logic                               csr_write,
   input  logic [rbhd_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [rbhd_pkg::CFG_W-1:0]         csr_wdata
);

   localparam int DIM_W = $clog2(MAX_WIDTH + 1);
   localparam int CMP_W = (DIM_W > rbhd_pkg::CFG_W) ? DIM_W : rbhd_pkg::CFG_W;

   logic [rbhd_pkg::CFG_W-1:0]  image_width_ff, image_height_ff, side_limit_ff;
   logic [rbhd_pkg::PASS_W-1:0] passes_ff, passes_in, passes_count, passes_now;
   logic [DIM_W-1:0]            width_clamped, height_clamped, cw, ch;
   logic                        csr_hit, at_origin, req_take;
   rbhd_pkg::token_type         tok   [MAX_PASSES+1];
   logic                        ready [MAX_PASSES+1];

   always_comb begin
      if (image_width_ff == '0) begin
         width_clamped = DIM_W'(1);
      end else if (int'(image_width_ff) > MAX_WIDTH) begin
         width_clamped = DIM_W'(MAX_WIDTH);
      end else begin
         width_clamped = DIM_W'(image_width_ff);
      end
      if (image_height_ff == '0) begin
         height_clamped = DIM_W'(1);
      end else if (int'(image_height_ff) > MAX_WIDTH) begin
         height_clamped = DIM_W'(MAX_WIDTH);
      end else begin
         height_clamped = DIM_W'(image_height_ff);
      end
   end

   always_comb begin
      cw           = width_clamped;
      ch           = height_clamped;
      passes_count = '0;
      for (int i = 0; i < MAX_PASSES; i++) begin
         if ((CMP_W'(cw) > CMP_W'(side_limit_ff) || CMP_W'(ch) > CMP_W'(side_limit_ff))
             && cw >= DIM_W'(2) && ch >= DIM_W'(2)) begin
            cw           = cw >> 1;
            ch           = ch >> 1;
            passes_count = rbhd_pkg::PASS_W'(passes_count + rbhd_pkg::PASS_W'(1));
         end
      end
   end

   always_comb begin
      unique case (csr_index)
         rbhd_pkg::REG_IMAGE_WIDTH,
         rbhd_pkg::REG_IMAGE_HEIGHT,
         rbhd_pkg::REG_SIDE_LIMIT: csr_hit = csr_write;
         default:                  csr_hit = 1'b0;
      endcase
   end

   assign passes_now = at_origin ? passes_count : passes_ff;
   assign req_take   = req_valid && !req_stall;
   assign passes_in  = req_take ? passes_now : passes_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff  <= rbhd_pkg::RESET_IMAGE_WIDTH;
         image_height_ff <= rbhd_pkg::RESET_IMAGE_HEIGHT;
         side_limit_ff   <= rbhd_pkg::RESET_SIDE_LIMIT;
         passes_ff       <= '0;
      end else begin
         if (csr_write) begin
            unique case (csr_index)
               rbhd_pkg::REG_IMAGE_WIDTH:  image_width_ff  <= csr_wdata;
               rbhd_pkg::REG_IMAGE_HEIGHT: image_height_ff <= csr_wdata;
               rbhd_pkg::REG_SIDE_LIMIT:   side_limit_ff   <= csr_wdata;
               default: ;
            endcase
         end
         passes_ff <= csr_hit ? '0 : passes_in;
      end
   end

   assign tok[0].valid        = req_valid;
   assign tok[0].last         = 1'b0;
   assign tok[0].passes       = passes_now;
   assign tok[0].pix[0]       = req_data.in_red;
   assign tok[0].pix[1]       = req_data.in_green;
   assign tok[0].pix[2]       = req_data.in_blue;
   assign tok[0].pix[3]       = req_data.in_alpha;
   assign ready[MAX_PASSES]   = !rsp_stall;
   assign req_stall           = !ready[0];

   for (genvar s = 0; s < MAX_PASSES; s++) begin : g_stage
      if (s == 0) begin : g_first
         rbhd_stage #(
            .STAGE     (s),
            .MAX_WIDTH (MAX_WIDTH)
         ) u_stage (
            .clock        (clock),
            .reset        (reset),
            .clear        (csr_hit),
            .image_width  (width_clamped),
            .image_height (height_clamped),
            .in_tok       (tok[s]),
            .in_ready     (ready[s]),
            .out_tok      (tok[s+1]),
            .out_ready    (ready[s+1]),
            .at_origin    (at_origin)
         );
      end else begin : g_later
         rbhd_stage #(
            .STAGE     (s),
            .MAX_WIDTH (MAX_WIDTH)
         ) u_stage (
            .clock        (clock),
            .reset        (reset),
            .clear        (csr_hit),
            .image_width  (width_clamped),
            .image_height (height_clamped),
            .in_tok       (tok[s]),
            .in_ready     (ready[s]),
            .out_tok      (tok[s+1]),
            .out_ready    (ready[s+1]),
            .at_origin    ()
         );
      end
   end

   assign rsp_valid          = tok[MAX_PASSES].valid;
   assign rsp_data.out_red   = tok[MAX_PASSES].pix[0];
   assign rsp_data.out_green = tok[MAX_PASSES].pix[1];
   assign rsp_data.out_blue  = tok[MAX_PASSES].pix[2];
   assign rsp_data.out_alpha = tok[MAX_PASSES].pix[3];
   assign rsp_data.frame_end = tok[MAX_PASSES].last;

endmodule

// ===== rtl/rbhd_checker.sv =====
// Port-level checker for the downscaler and its bind to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module rbhd_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_stall,
   input logic                   rsp_valid,
   input logic                   rsp_stall,
   input rbhd_pkg::rsp_data_type rsp_data
);

   // The input side is only held back when a result transaction is waiting.
   `RBHD_ASSERT(a_stall_cause, clock, reset, req_stall |-> (rsp_valid && rsp_stall), "input stalled without a waiting result")
   // Reset leaves no result behind.
   `RBHD_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_valid, "result valid straight after reset")
   // A stalled result stays offered.
   `RBHD_ASSERT(a_rsp_hold, clock, reset, (rsp_valid && rsp_stall) |=> rsp_valid, "result withdrawn while stalled")
   // A stalled result keeps its payload.
   `RBHD_ASSERT(a_rsp_stable, clock, reset, (rsp_valid && rsp_stall) |=> $stable(rsp_data), "result changed while stalled")

endmodule

bind rgba_box_halving_downscaler_unit rbhd_checker u_rbhd_checker (.*);
